// ----- hw/rtl/wrdd_pkg.sv -----
package wrdd_pkg;

    localparam int PERIOD_DEF = 14;
    localparam int LAG_DEF    = 2;

    localparam int PRICE_W    = 24;
    localparam int SUM_W      = 30;
    localparam int AVG_W      = 40;
    localparam int FRAC_W     = 16;
    localparam int RSI_W      = 17;
    localparam int NUM_W      = AVG_W + RSI_W;
    localparam int DEN_W      = AVG_W + 1;
    localparam int DIV_W      = 48;
    localparam int DIV_DIGITS = 8;

    localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(102400);

    localparam int GAP_W   = 8;
    localparam int RUN_W   = 7;
    localparam int DAYS_W  = 8;
    localparam int CHAIN_W = 7;
    localparam logic [DAYS_W-1:0]  DAYS_MAX  = DAYS_W'(255);
    localparam logic [CHAIN_W-1:0] CHAIN_MAX = CHAIN_W'(64);
    localparam logic [GAP_W-1:0]   GAP_RST   = GAP_W'(7);
    localparam logic [RUN_W-1:0]   RUN_RST   = RUN_W'(3);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH = CFG_IDX_W'(1);

    localparam int CMD_DEPTH = 2;

    typedef logic [1:0] t_op;
    localparam t_op OP_WARM   = 2'd0;
    localparam t_op OP_SEED   = 2'd1;
    localparam t_op OP_SMOOTH = 2'd2;

    typedef struct packed {
        t_op                op;
        logic [SUM_W-1:0]   xg;
        logic [SUM_W-1:0]   xl;
        logic [PRICE_W-1:0] close;
        logic               check;
    } t_cmd;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [RSI_W-1:0] rsi;
        logic             rsi_valid;
        logic             dis;
        logic             cons;
    } t_result;

endpackage

// ----- hw/rtl/wrdd_front.sv -----
module wrdd_front #(
    parameter int PERIOD = wrdd_pkg::PERIOD_DEF,
    parameter int LAG    = wrdd_pkg::LAG_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [wrdd_pkg::PRICE_W-1:0] i_close_price,
    input  logic                         i_fifo_full,
    output logic                         o_wr,
    output wrdd_pkg::t_cmd               o_cmd
);

    localparam int CNT_W = $clog2(PERIOD + LAG + 1);

    logic [CNT_W-1:0]             r_count;
    logic [wrdd_pkg::PRICE_W-1:0] r_last_close;
    logic [wrdd_pkg::SUM_W-1:0]   r_gain_sum;
    logic [wrdd_pkg::SUM_W-1:0]   r_loss_sum;

    logic [wrdd_pkg::PRICE_W-1:0] gain;
    logic [wrdd_pkg::PRICE_W-1:0] loss;
    logic [wrdd_pkg::SUM_W-1:0]   n_gain_sum;
    logic [wrdd_pkg::SUM_W-1:0]   n_loss_sum;

    assign o_wr = i_push && !i_fifo_full;

    always_comb begin
        gain = '0;
        loss = '0;
        if (r_count != '0) begin
            if (i_close_price > r_last_close) begin
                gain = i_close_price - r_last_close;
            end else begin
                loss = r_last_close - i_close_price;
            end
        end
        n_gain_sum = r_gain_sum + wrdd_pkg::SUM_W'(gain);
        n_loss_sum = r_loss_sum + wrdd_pkg::SUM_W'(loss);

        o_cmd.close = i_close_price;
        o_cmd.check = r_count >= CNT_W'(PERIOD + LAG);
        priority if (r_count < CNT_W'(PERIOD)) begin
            o_cmd.op = wrdd_pkg::OP_WARM;
            o_cmd.xg = '0;
            o_cmd.xl = '0;
        end else if (r_count == CNT_W'(PERIOD)) begin
            // sums of the first changes seed the averages
            o_cmd.op = wrdd_pkg::OP_SEED;
            o_cmd.xg = n_gain_sum;
            o_cmd.xl = n_loss_sum;
        end else begin
            o_cmd.op = wrdd_pkg::OP_SMOOTH;
            o_cmd.xg = wrdd_pkg::SUM_W'(gain);
            o_cmd.xl = wrdd_pkg::SUM_W'(loss);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_close <= '0;
            r_gain_sum   <= '0;
            r_loss_sum   <= '0;
        end else if (o_wr) begin
            r_last_close <= i_close_price;
            if (r_count <= CNT_W'(PERIOD)) begin
                r_gain_sum <= n_gain_sum;
                r_loss_sum <= n_loss_sum;
            end
            if (r_count < CNT_W'(PERIOD + LAG)) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/wrdd_fifo.sv -----
module wrdd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  wrdd_pkg::t_cmd i_wdata,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_rd,
    output wrdd_pkg::t_cmd o_rdata
);

    localparam int DEPTH = wrdd_pkg::CMD_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wrdd_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_rdata = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/wrdd_div.sv -----
module wrdd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wrdd_pkg::NUM_W-1:0]   i_num,
    input  logic [wrdd_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [wrdd_pkg::RSI_W-1:0]   o_quot
);

    localparam int QW    = wrdd_pkg::RSI_W;
    localparam int DW    = wrdd_pkg::DEN_W;
    localparam int CNT_W = $clog2(QW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_q;
    logic [DW-1:0]    r_den;

    logic [DW:0] sh;
    logic [DW:0] diff;
    logic        ge;

    assign o_done = r_done;
    assign o_quot = r_q;

    // restoring division, one quotient bit a cycle; the quotient is known to fit in QW bits
    always_comb begin
        sh   = {r_rem, r_q[QW-1]};
        ge   = sh >= {1'b0, r_den};
        diff = sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_num[wrdd_pkg::NUM_W-1:QW]);
            r_q   <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : sh[DW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/wrdd_back.sv -----
module wrdd_back #(
    parameter int PERIOD = wrdd_pkg::PERIOD_DEF,
    parameter int LAG    = wrdd_pkg::LAG_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrdd_pkg::t_cfg_wr i_cfg,
    input  logic              i_fifo_empty,
    input  wrdd_pkg::t_cmd    i_cmd,
    output logic              o_fifo_rd,
    output logic              o_out_vld,
    output wrdd_pkg::t_result o_out,
    input  logic              i_pop
);

    localparam int RW       = $clog2(2 * PERIOD);
    localparam int CD_CYC   = wrdd_pkg::DIV_W / wrdd_pkg::DIV_DIGITS;
    localparam int CD_CNT_W = (CD_CYC > 1) ? $clog2(CD_CYC) : 1;
    localparam int AW       = wrdd_pkg::AVG_W;
    localparam int DVW      = wrdd_pkg::DIV_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CDIV = 3'd2;
    localparam logic [2:0] S_RMUL = 3'd3;
    localparam logic [2:0] S_RDIV = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]                   r_state;
    wrdd_pkg::t_cmd               r_cmd;
    logic [CD_CNT_W-1:0]          r_cnt;
    logic [DVW-1:0]               r_dg;
    logic [DVW-1:0]               r_dl;
    logic [RW-1:0]                r_rg;
    logic [RW-1:0]                r_rl;
    logic [AW-1:0]                r_avg_g;
    logic [AW-1:0]                r_avg_l;
    logic [wrdd_pkg::RSI_W-1:0]   r_rsi;
    logic [wrdd_pkg::RSI_W-1:0]   r_rsi_hist   [LAG];
    logic [wrdd_pkg::PRICE_W-1:0] r_close_hist [LAG];
    logic [wrdd_pkg::DAYS_W-1:0]  r_days;
    logic [wrdd_pkg::CHAIN_W-1:0] r_chain;
    logic [wrdd_pkg::GAP_W-1:0]   r_gap_limit;
    logic [wrdd_pkg::RUN_W-1:0]   r_run_length;
    logic                         r_out_vld;
    wrdd_pkg::t_result            r_out;

    logic [DVW-1:0]               n_dg;
    logic [DVW-1:0]               n_dl;
    logic [RW-1:0]                n_rg;
    logic [RW-1:0]                n_rl;
    logic [DVW-1:0]               mul_g;
    logic [DVW-1:0]               mul_l;
    logic [RW-1:0]                tg;
    logic [RW-1:0]                tl;
    logic [wrdd_pkg::NUM_W-1:0]   rsi_num;
    logic [wrdd_pkg::DEN_W-1:0]   rsi_den;
    logic                         div_start;
    logic                         div_done;
    logic [wrdd_pkg::RSI_W-1:0]   div_quot;
    logic                         commit;
    logic                         rsi_up;
    logic                         close_up;
    logic                         dis;
    logic [wrdd_pkg::DAYS_W:0]    gap;
    logic [wrdd_pkg::CHAIN_W-1:0] n_chain;
    logic [wrdd_pkg::DAYS_W-1:0]  n_days;
    logic                         cons;

    assign o_fifo_rd = (r_state == S_IDLE) && !i_fifo_empty;
    assign o_out_vld = r_out_vld;
    assign o_out     = r_out;
    assign commit    = (r_state == S_FIN) && (!r_out_vld || i_pop);
    assign div_start = (r_state == S_RMUL) && (rsi_den != '0);

    // wilder step: ((period-1)*avg + x) / period, or the seed sum / period
    always_comb begin
        if (r_cmd.op == wrdd_pkg::OP_SEED) begin
            mul_g = DVW'(r_cmd.xg) << wrdd_pkg::FRAC_W;
            mul_l = DVW'(r_cmd.xl) << wrdd_pkg::FRAC_W;
        end else begin
            mul_g = DVW'(r_avg_g) * DVW'(PERIOD - 1) + (DVW'(r_cmd.xg) << wrdd_pkg::FRAC_W);
            mul_l = DVW'(r_avg_l) * DVW'(PERIOD - 1) + (DVW'(r_cmd.xl) << wrdd_pkg::FRAC_W);
        end
    end

    // divide by period, a byte of quotient per cycle on both lanes
    always_comb begin
        n_dg = r_dg;
        n_dl = r_dl;
        n_rg = r_rg;
        n_rl = r_rl;
        for (int i = 0; i < wrdd_pkg::DIV_DIGITS; i++) begin
            tg   = {n_rg[RW-2:0], n_dg[DVW-1]};
            tl   = {n_rl[RW-2:0], n_dl[DVW-1]};
            n_dg = {n_dg[DVW-2:0], 1'b0};
            n_dl = {n_dl[DVW-2:0], 1'b0};
            if (tg >= RW'(PERIOD)) begin
                tg      = tg - RW'(PERIOD);
                n_dg[0] = 1'b1;
            end
            if (tl >= RW'(PERIOD)) begin
                tl      = tl - RW'(PERIOD);
                n_dl[0] = 1'b1;
            end
            n_rg = tg;
            n_rl = tl;
        end
    end

    always_comb begin
        rsi_num = wrdd_pkg::NUM_W'(r_avg_g) * wrdd_pkg::NUM_W'(wrdd_pkg::RSI_FULL);
        rsi_den = wrdd_pkg::DEN_W'(r_avg_g) + wrdd_pkg::DEN_W'(r_avg_l);
    end

    wrdd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (rsi_num),
        .i_den   (rsi_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // trend checks and the disagreement chain
    always_comb begin
        rsi_up   = r_rsi > r_rsi_hist[LAG-1];
        close_up = r_cmd.close > r_close_hist[LAG-1];
        dis      = r_cmd.check && (rsi_up != close_up);
        gap      = {1'b0, r_days} + (wrdd_pkg::DAYS_W + 1)'(1);
        if (r_chain != '0 && gap <= {1'b0, r_gap_limit}) begin
            n_chain = (r_chain < wrdd_pkg::CHAIN_MAX) ? r_chain + wrdd_pkg::CHAIN_W'(1)
                                                      : r_chain;
        end else begin
            n_chain = wrdd_pkg::CHAIN_W'(1);
        end
        cons = dis && (n_chain >= r_run_length);
        if (dis) begin
            n_days = '0;
        end else if (r_cmd.check && r_days < wrdd_pkg::DAYS_MAX) begin
            n_days = r_days + wrdd_pkg::DAYS_W'(1);
        end else begin
            n_days = r_days;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fifo_rd) begin
            r_cmd <= i_cmd;
        end
        unique case (r_state)
            S_MUL: begin
                r_dg <= mul_g;
                r_dl <= mul_l;
                r_rg <= '0;
                r_rl <= '0;
            end
            S_CDIV: begin
                r_dg <= n_dg;
                r_dl <= n_dl;
                r_rg <= n_rg;
                r_rl <= n_rl;
            end
            default: begin
            end
        endcase
        if (commit) begin
            r_out.rsi       <= r_rsi;
            r_out.rsi_valid <= r_cmd.op != wrdd_pkg::OP_WARM;
            r_out.dis       <= dis;
            r_out.cons      <= cons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_avg_g      <= '0;
            r_avg_l      <= '0;
            r_rsi        <= '0;
            r_days       <= wrdd_pkg::DAYS_MAX;
            r_chain      <= '0;
            r_gap_limit  <= wrdd_pkg::GAP_RST;
            r_run_length <= wrdd_pkg::RUN_RST;
            r_out_vld    <= 1'b0;
            for (int k = 0; k < LAG; k++) begin
                r_rsi_hist[k]   <= '0;
                r_close_hist[k] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == wrdd_pkg::CFG_GAP_LIMIT) begin
                    r_gap_limit <= i_cfg.data[wrdd_pkg::GAP_W-1:0];
                end else if (i_cfg.index == wrdd_pkg::CFG_RUN_LENGTH) begin
                    r_run_length <= i_cfg.data[wrdd_pkg::RUN_W-1:0];
                end
            end

            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (o_fifo_rd) begin
                        r_cnt <= '0;
                        if (i_cmd.op == wrdd_pkg::OP_WARM) begin
                            r_rsi   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    r_cnt <= r_cnt + CD_CNT_W'(1);
                    if (r_cnt == CD_CNT_W'(CD_CYC - 1)) begin
                        r_avg_g <= n_dg[AW-1:0];
                        r_avg_l <= n_dl[AW-1:0];
                        r_state <= S_RMUL;
                    end
                end
                S_RMUL: begin
                    if (rsi_den == '0) begin
                        // flat market reads as full scale
                        r_rsi   <= wrdd_pkg::RSI_FULL;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (div_done) begin
                        r_rsi   <= div_quot;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (commit) begin
                        r_days  <= n_days;
                        if (dis) begin
                            r_chain <= n_chain;
                        end
                        r_rsi_hist[0]   <= r_rsi;
                        r_close_hist[0] <= r_cmd.close;
                        for (int k = 1; k < LAG; k++) begin
                            r_rsi_hist[k]   <= r_rsi_hist[k-1];
                            r_close_hist[k] <= r_close_hist[k-1];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cons_needs_dis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.cons |-> r_out.dis)
        else $error("consecutive flag without disagreement");

    a_warm_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.rsi_valid |-> (r_out.rsi == '0) && !r_out.dis)
        else $error("warm-up word carries rsi or flag");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out.rsi <= wrdd_pkg::RSI_FULL)
        else $error("rsi above full scale");

    a_chain_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chain <= wrdd_pkg::CHAIN_MAX)
        else $error("chain length past saturation");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_RDIV)
        else $error("divider finished outside rsi divide state");

endmodule

// ----- hw/rtl/wilder_rsi_divergence_detector.sv -----
// channel   direction  handshake                     payload
// input     in         push / full                   i_close_price
// result    out        empty / pop                   o_rsi_value, o_rsi_valid,
//                                                    o_disagreement, o_consecutive_disagreement
// config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// back end per word: a queue read, then a warm-up word goes straight to retire;
// a word with an rsi passes through read, multiply, the divide-by-period steps,
// divider setup, the serial rsi divider, retire.
// with both averages zero the rsi divider is skipped and the word goes on to retire.
// an unpopped result holds the back end in its retire cycle; the two-word command queue
// keeps taking input, full rises only when both slots are taken. reset is synchronous,
// active low; config writes are always ready.
module wilder_rsi_divergence_detector #(
    parameter int PERIOD = wrdd_pkg::PERIOD_DEF,
    parameter int LAG    = wrdd_pkg::LAG_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [wrdd_pkg::PRICE_W-1:0]    i_close_price,
    output logic                            empty,
    input  logic                            pop,
    output logic [wrdd_pkg::RSI_W-1:0]      o_rsi_value,
    output logic                            o_rsi_valid,
    output logic                            o_disagreement,
    output logic                            o_consecutive_disagreement,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wrdd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wrdd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic              fifo_wr;
    logic              fifo_full;
    logic              fifo_empty;
    logic              fifo_rd;
    wrdd_pkg::t_cmd    cmd_in;
    wrdd_pkg::t_cmd    cmd_out;
    wrdd_pkg::t_cfg_wr cfg;
    logic              out_vld;
    wrdd_pkg::t_result out_word;

    assign full        = fifo_full;
    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    wrdd_front #(
        .PERIOD (PERIOD),
        .LAG    (LAG)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_close_price (i_close_price),
        .i_fifo_full   (fifo_full),
        .o_wr          (fifo_wr),
        .o_cmd         (cmd_in)
    );

    wrdd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .i_wdata (cmd_in),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .i_rd    (fifo_rd),
        .o_rdata (cmd_out)
    );

    wrdd_back #(
        .PERIOD (PERIOD),
        .LAG    (LAG)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_fifo_empty (fifo_empty),
        .i_cmd        (cmd_out),
        .o_fifo_rd    (fifo_rd),
        .o_out_vld    (out_vld),
        .o_out        (out_word),
        .i_pop        (pop)
    );

    assign empty                      = !out_vld;
    assign o_rsi_value                = out_word.rsi;
    assign o_rsi_valid                = out_word.rsi_valid;
    assign o_disagreement             = out_word.dis;
    assign o_consecutive_disagreement = out_word.cons;

endmodule
